>>> src/bttf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bttf_pkg;

  localparam int OFF_W = 37;

  typedef logic signed [OFF_W-1:0] off_t;
  typedef logic [1:0] status_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_ZERO    = 2'd1;
  localparam status_t ST_NOFIT   = 2'd2;
  localparam status_t ST_IGNORED = 2'd3;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h0040_0000;
  localparam logic [16:0] HEAP_SIZE_RESET = 17'h1_0000;

  localparam logic [31:0] TAG_MAGIC = 32'hEC32_BEEF;
  localparam int HDR_BYTES  = 20;
  localparam int FTR_BYTES  = 8;
  localparam int TAGS_BYTES = HDR_BYTES + FTR_BYTES;
  localparam int SPLIT_MIN  = HDR_BYTES + 16 + FTR_BYTES;

  function automatic off_t ext32(input logic [31:0] v);
    return off_t'({{(OFF_W-32){1'b0}}, v});
  endfunction

  function automatic off_t dec_link(input logic [31:0] l);
    return (ext32(l) - off_t'(1)) <<< 2;
  endfunction

  function automatic logic [31:0] enc_link(input off_t o);
    return o[33:2] + 32'd1;
  endfunction

endpackage

`default_nettype wire

>>> src/bttf_tag_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bttf_tag_ram #(
  parameter int DEPTH = 16384,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          re,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        q,
  output logic               busy
);

  logic [31:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // zeroing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 32'd0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> src/bttf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bttf_seq #(
  parameter int HEAP_WORDS = 16384,
  parameter int AW = $clog2(HEAP_WORDS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [31:0]           heap_base,
  input  wire logic [16:0]           heap_size,
  input  wire logic                  clr_busy,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [16:0]           request_size,
  input  wire logic [31:0]           release_address,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                block_address,
  output bttf_pkg::status_t          status,
  output logic                       mem_re,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_addr,
  output logic [31:0]                mem_wdata,
  input  wire logic [31:0]           mem_q
);

  import bttf_pkg::*;

  localparam int WALK_LIMIT = HEAP_WORDS / 7 + 1;
  localparam int SW = $clog2(WALK_LIMIT + 1);
  localparam off_t CAP = off_t'(HEAP_WORDS) <<< 2;

  typedef enum logic [5:0] {
    S_IDLE, S_DONE,
    S_AL_WALK, S_AL_W1, S_AL_W2, S_AL_W3,
    S_AL_OLD, S_AL_OLD2, S_AL_S2, S_AL_S3, S_AL_S4, S_AL_FIN, S_AL_FIN2, S_AL_END,
    S_RL0, S_RL1, S_RL2, S_RL3, S_RL4, S_RL5, S_RL6, S_RL7, S_RL7B,
    S_RL8, S_RL9, S_RL10, S_RL11, S_RL12, S_RL13, S_RL14, S_RL15, S_RL_PUSH,
    S_IN0, S_IN1, S_IN2, S_IN3,
    S_SB0, S_SB1, S_SB2, S_SB3,
    S_UL0, S_UL1, S_UL2, S_UL3, S_UL4, S_UL5,
    S_PU0, S_PU1, S_PU2
  } state_t;

  state_t state, ret;

  logic [31:0] free_head;
  logic [31:0] size, old, link, ptr, flag, ul_nx, ul_pv;
  logic [SW-1:0] steps;
  off_t cur, blk, rest, roff, nxt, ph;
  off_t arg_off;
  logic [31:0] arg_size, arg_free;
  logic rd_oob;
  logic [31:0] res_addr;
  status_t res_status;

  logic [31:0] rdv;
  off_t hs_len, len, off_c, nxt_c, pf_c, sb_tail;
  logic rel_bad, fit, walk_stop;

  logic req_rd, req_wr, inb;
  off_t req_off;
  logic [31:0] req_data;

  assign rdv = rd_oob ? 32'd0 : mem_q;
  assign hs_len = ext32({15'd0, heap_size[16:2], 2'b00});
  assign len = (hs_len < CAP) ? hs_len : CAP;
  assign off_c = ext32(ptr) - ext32(heap_base) - off_t'(HDR_BYTES);
  assign rel_bad = (ptr == 32'd0) || off_c[OFF_W-1] || (off_c[1:0] != 2'b00) ||
                   (off_c + off_t'(TAGS_BYTES) > len);
  assign nxt_c = roff + off_t'(TAGS_BYTES) + ext32(size);
  assign pf_c = roff - off_t'(FTR_BYTES);
  assign sb_tail = arg_off + off_t'(HDR_BYTES) + ext32(arg_size);
  assign fit = (flag != 32'd0) && (rdv >= size);
  assign walk_stop = (link == 32'd0) || (steps >= SW'(WALK_LIMIT));

  always_comb begin
    req_rd = 1'b0;
    req_wr = 1'b0;
    req_off = '0;
    req_data = 32'd0;
    unique case (state)
      S_AL_WALK: begin
        req_rd = !walk_stop;
        req_off = dec_link(link) + off_t'(4);
      end
      S_AL_W1: begin
        req_rd = 1'b1;
        req_off = cur;
      end
      S_AL_W2: begin
        req_rd = !fit;
        req_off = cur + off_t'(8);
      end
      S_AL_OLD, S_AL_FIN: begin
        req_rd = 1'b1;
        req_off = blk;
      end
      S_AL_S3: begin
        req_wr = 1'b1;
        req_off = rest + off_t'(16);
        req_data = TAG_MAGIC;
      end
      S_RL0: begin
        req_rd = !rel_bad;
        req_off = off_c + off_t'(16);
      end
      S_RL1: begin
        req_rd = (rdv == TAG_MAGIC);
        req_off = roff + off_t'(4);
      end
      S_RL2: begin
        req_rd = (rdv == 32'd0);
        req_off = roff;
      end
      S_RL4: begin
        req_rd = (nxt_c < len);
        req_off = nxt_c + off_t'(4);
      end
      S_RL5: begin
        req_rd = (rdv != 32'd0);
        req_off = nxt + off_t'(16);
      end
      S_RL7: begin
        req_rd = 1'b1;
        req_off = nxt;
      end
      S_RL8: begin
        req_rd = !pf_c[OFF_W-1];
        req_off = pf_c;
      end
      S_RL10: begin
        req_rd = 1'b1;
        req_off = ph + off_t'(4);
      end
      S_RL11: begin
        req_rd = (rdv != 32'd0);
        req_off = ph + off_t'(16);
      end
      S_RL13: begin
        req_rd = 1'b1;
        req_off = ph;
      end
      S_IN1: begin
        req_wr = 1'b1;
        req_off = off_t'(16);
        req_data = TAG_MAGIC;
      end
      S_IN2: begin
        req_wr = 1'b1;
        req_off = off_t'(8);
      end
      S_IN3: begin
        req_wr = 1'b1;
        req_off = off_t'(12);
      end
      S_SB0: begin
        req_wr = 1'b1;
        req_off = arg_off;
        req_data = arg_size;
      end
      S_SB1: begin
        req_wr = 1'b1;
        req_off = arg_off + off_t'(4);
        req_data = arg_free;
      end
      S_SB2: begin
        req_wr = 1'b1;
        req_off = sb_tail;
        req_data = arg_size;
      end
      S_SB3: begin
        req_wr = 1'b1;
        req_off = sb_tail + off_t'(4);
        req_data = arg_free;
      end
      S_UL0: begin
        req_rd = 1'b1;
        req_off = arg_off + off_t'(8);
      end
      S_UL1: begin
        req_rd = 1'b1;
        req_off = arg_off + off_t'(12);
      end
      S_UL2: begin
        req_wr = (rdv != 32'd0);
        req_off = dec_link(rdv) + off_t'(8);
        req_data = ul_nx;
      end
      S_UL3: begin
        req_wr = (ul_nx != 32'd0);
        req_off = dec_link(ul_nx) + off_t'(12);
        req_data = ul_pv;
      end
      S_UL4, S_PU0: begin
        req_wr = 1'b1;
        req_off = arg_off + off_t'(8);
        req_data = (state == S_PU0) ? free_head : 32'd0;
      end
      S_UL5, S_PU1: begin
        req_wr = 1'b1;
        req_off = arg_off + off_t'(12);
      end
      S_PU2: begin
        req_wr = (free_head != 32'd0);
        req_off = dec_link(free_head) + off_t'(12);
        req_data = enc_link(arg_off);
      end
      default: begin
      end
    endcase
  end

  assign inb = !req_off[OFF_W-1] && (req_off < len);
  assign mem_re = req_rd;
  assign mem_we = req_wr && inb;
  assign mem_addr = req_off[AW+1:2];
  assign mem_wdata = req_data;
  assign in_stall = (state != S_IDLE) || clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      free_head <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (req_rd) begin
        rd_oob <= !inb;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            ptr <= release_address;
            size <= ({15'd0, request_size} + 32'd7) & ~32'd7;
            link <= free_head;
            steps <= '0;
            res_addr <= 32'd0;
            res_status <= ST_DONE;
            case (opcode)
              OP_ALLOC: begin
                if (request_size == 17'd0) begin
                  res_status <= ST_ZERO;
                  state <= S_DONE;
                end else begin
                  state <= S_AL_WALK;
                end
              end
              OP_RELEASE: state <= S_RL0;
              OP_INIT: state <= S_IN0;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            block_address <= res_addr;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        S_AL_WALK: begin
          if (walk_stop) begin
            res_status <= ST_NOFIT;
            state <= S_DONE;
          end else begin
            cur <= dec_link(link);
            state <= S_AL_W1;
          end
        end
        S_AL_W1: begin
          flag <= rdv;
          state <= S_AL_W2;
        end
        S_AL_W2: begin
          if (fit) begin
            blk <= cur;
            arg_off <= cur;
            ret <= S_AL_OLD;
            state <= S_UL0;
          end else begin
            state <= S_AL_W3;
          end
        end
        S_AL_W3: begin
          link <= rdv;
          steps <= steps + SW'(1);
          state <= S_AL_WALK;
        end
        S_AL_OLD: state <= S_AL_OLD2;
        S_AL_OLD2: begin
          old <= rdv;
          if (ext32(rdv) >= ext32(size) + off_t'(SPLIT_MIN)) begin
            rest <= blk + off_t'(TAGS_BYTES) + ext32(size);
            arg_off <= blk;
            arg_size <= size;
            arg_free <= 32'd0;
            ret <= S_AL_S2;
            state <= S_SB0;
          end else begin
            state <= S_AL_FIN;
          end
        end
        S_AL_S2: begin
          arg_off <= rest;
          arg_size <= old - size - 32'(TAGS_BYTES);
          arg_free <= 32'd1;
          ret <= S_AL_S3;
          state <= S_SB0;
        end
        S_AL_S3: state <= S_AL_S4;
        S_AL_S4: begin
          arg_off <= rest;
          ret <= S_AL_FIN;
          state <= S_PU0;
        end
        S_AL_FIN: state <= S_AL_FIN2;
        S_AL_FIN2: begin
          arg_off <= blk;
          arg_size <= rdv;
          arg_free <= 32'd0;
          ret <= S_AL_END;
          state <= S_SB0;
        end
        S_AL_END: begin
          res_addr <= heap_base + blk[31:0] + 32'(HDR_BYTES);
          state <= S_DONE;
        end
        S_RL0: begin
          roff <= off_c;
          if (rel_bad) begin
            res_status <= ST_IGNORED;
            state <= S_DONE;
          end else begin
            state <= S_RL1;
          end
        end
        S_RL1: begin
          if (rdv != TAG_MAGIC) begin
            res_status <= ST_IGNORED;
            state <= S_DONE;
          end else begin
            state <= S_RL2;
          end
        end
        S_RL2: begin
          if (rdv != 32'd0) begin
            res_status <= ST_IGNORED;
            state <= S_DONE;
          end else begin
            state <= S_RL3;
          end
        end
        S_RL3: begin
          size <= rdv;
          arg_off <= roff;
          arg_size <= rdv;
          arg_free <= 32'd1;
          ret <= S_RL4;
          state <= S_SB0;
        end
        S_RL4: begin
          nxt <= nxt_c;
          state <= (nxt_c < len) ? S_RL5 : S_RL8;
        end
        S_RL5: state <= (rdv != 32'd0) ? S_RL6 : S_RL8;
        S_RL6: begin
          if (rdv == TAG_MAGIC) begin
            arg_off <= nxt;
            ret <= S_RL7;
            state <= S_UL0;
          end else begin
            state <= S_RL8;
          end
        end
        S_RL7: state <= S_RL7B;
        S_RL7B: begin
          size <= size + 32'(TAGS_BYTES) + rdv;
          arg_off <= roff;
          arg_size <= size + 32'(TAGS_BYTES) + rdv;
          arg_free <= 32'd1;
          ret <= S_RL8;
          state <= S_SB0;
        end
        S_RL8: state <= pf_c[OFF_W-1] ? S_RL_PUSH : S_RL9;
        S_RL9: begin
          ph <= pf_c - off_t'(HDR_BYTES) - ext32(rdv);
          state <= S_RL10;
        end
        S_RL10: state <= S_RL11;
        S_RL11: state <= (rdv != 32'd0) ? S_RL12 : S_RL_PUSH;
        S_RL12: begin
          if (rdv == TAG_MAGIC) begin
            arg_off <= ph;
            ret <= S_RL13;
            state <= S_UL0;
          end else begin
            state <= S_RL_PUSH;
          end
        end
        S_RL13: state <= S_RL14;
        S_RL14: begin
          arg_off <= ph;
          arg_size <= rdv + 32'(TAGS_BYTES) + size;
          arg_free <= 32'd1;
          ret <= S_RL15;
          state <= S_SB0;
        end
        S_RL15: begin
          arg_off <= ph;
          ret <= S_DONE;
          state <= S_PU0;
        end
        S_RL_PUSH: begin
          arg_off <= roff;
          ret <= S_DONE;
          state <= S_PU0;
        end
        S_IN0: begin
          free_head <= 32'd0;
          if (len < off_t'(TAGS_BYTES)) begin
            state <= S_DONE;
          end else begin
            arg_off <= '0;
            arg_size <= 32'(len - off_t'(TAGS_BYTES));
            arg_free <= 32'd1;
            ret <= S_IN1;
            state <= S_SB0;
          end
        end
        S_IN1: state <= S_IN2;
        S_IN2: state <= S_IN3;
        S_IN3: begin
          free_head <= 32'd1;
          state <= S_DONE;
        end
        S_SB0: state <= S_SB1;
        S_SB1: state <= S_SB2;
        S_SB2: state <= S_SB3;
        S_SB3: state <= ret;
        S_UL0: state <= S_UL1;
        S_UL1: begin
          ul_nx <= rdv;
          state <= S_UL2;
        end
        S_UL2: begin
          ul_pv <= rdv;
          if (rdv == 32'd0) begin
            free_head <= ul_nx;
          end
          state <= S_UL3;
        end
        S_UL3: state <= S_UL4;
        S_UL4: state <= S_UL5;
        S_UL5: state <= ret;
        S_PU0: state <= S_PU1;
        S_PU1: state <= S_PU2;
        S_PU2: begin
          free_head <= enc_link(arg_off);
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/boundary_tag_first_fit_heap_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Boundary-tag first-fit heap manager. Headers and footers of all blocks live
// in a single-port tag RAM of HEAP_WORDS 32-bit words whose read data is
// registered; every tag access is issued by the sequencer. After reset the
// tag RAM is zeroed, one word a cycle, so no request is taken until the
// zeroing pass ends (configuration writes are taken at any time). An allocate
// walks the free list, then unlinks, splits and tags the chosen block. One
// request is worked on at a time; the result register lets the next request
// enter while a result still waits to be taken.
module boundary_tag_first_fit_heap_core #(
  parameter int HEAP_WORDS = 16384
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        opcode,
  input  wire logic [16:0]       request_size,
  input  wire logic [31:0]       release_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            block_address,
  output bttf_pkg::status_t      status,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data
);

  import bttf_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);

  logic [31:0] heap_base;
  logic [16:0] heap_size;
  logic mem_re, mem_we, clr_busy;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RESET;
      heap_size <= HEAP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAP_BASE: heap_base <= cfg_data;
        CFG_HEAP_SIZE: heap_size <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  bttf_tag_ram #(
    .DEPTH(HEAP_WORDS),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .rst(rst),
    .re(mem_re),
    .we(mem_we),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .q(mem_q),
    .busy(clr_busy)
  );

  bttf_seq #(
    .HEAP_WORDS(HEAP_WORDS),
    .AW(AW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .heap_base(heap_base),
    .heap_size(heap_size),
    .clr_busy(clr_busy),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .request_size(request_size),
    .release_address(release_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .block_address(block_address),
    .status(status),
    .mem_re(mem_re),
    .mem_we(mem_we),
    .mem_addr(mem_addr),
    .mem_wdata(mem_wdata),
    .mem_q(mem_q)
  );

endmodule

`default_nettype wire
